// ----- design/hctd_pkg.sv -----
package hctd_pkg;

    localparam int MAX_NODES_DEF     = 511;
    localparam int MAX_CODE_LEN_DEF  = 32;
    localparam int BITS_PER_ITEM_DEF = 32;

    localparam int SYM_W  = 8;
    localparam int BITS_W = 32;
    localparam int LEN_W  = 6;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DECODE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    typedef enum logic {
        KIND_SYMBOL = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_STEP,
        S_FETCH,
        S_EMIT,
        S_ALLOC,
        S_SETSYM,
        S_FINISH
    } t_state;

endpackage

// ----- design/huffman_code_table_decoder.sv -----
// Huffman code table decoder. A code tree lives in a node memory with one
// write port and one registered read port; the root is held in flip-flops.
// One item is taken at a time and o_s_axis_tready stays low until its status
// item has been handed to the output register. A clear or a rejected item
// goes straight to its status item. An insert follows existing branches bit
// by bit, then, if the memory has room for them all, allocates one new node
// per remaining bit, and sets the symbol. A decode walks the tree bit by
// bit, emits a symbol at each leaf and restarts at the root, and resumes
// where the last item stopped. Each tree step waits for the registered read
// of the next node. Output back-pressure stalls only at symbol and status
// items.
module huffman_code_table_decoder #(
    parameter int MAX_NODES     = hctd_pkg::MAX_NODES_DEF,
    parameter int MAX_CODE_LEN  = hctd_pkg::MAX_CODE_LEN_DEF,
    parameter int BITS_PER_ITEM = hctd_pkg::BITS_PER_ITEM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // symbol[7:0], bits[39:8], bit_count[45:40], zero pad
    input  logic [hctd_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // action[1:0]
    input  logic [hctd_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // decoded_symbol[7:0], status[9:8], zero pad
    output logic [hctd_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // kind[0]
    output logic [hctd_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import hctd_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef struct packed {
        logic [NODE_W-1:0] lchild;
        logic [NODE_W-1:0] rchild;
        logic [SYM_W-1:0]  sym;
    } t_node;

    t_node r_mem [MAX_NODES];

    t_state             r_state, n_state;
    t_node              r_root, n_root;
    t_node              r_cur, n_cur;
    t_node              r_rdata;
    logic [NODE_W-1:0]  r_node, n_node;
    logic [NODE_W-1:0]  r_walk, n_walk;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [BITS_W-1:0]  r_bits, n_bits;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_insert, n_insert;
    t_status            r_status, n_status;
    logic [SYM_W-1:0]   r_emit_sym, n_emit_sym;

    logic               r_out_valid, n_out_valid;
    t_kind              r_out_kind, n_out_kind;
    logic [SYM_W-1:0]   r_out_sym, n_out_sym;
    t_status            r_out_status, n_out_status;
    logic               r_out_last, n_out_last;

    logic               w_in_acc;
    t_action            w_in_act;
    logic [SYM_W-1:0]   w_in_sym;
    logic [BITS_W-1:0]  w_in_bits;
    logic [LEN_W-1:0]   w_in_len;
    logic               w_ins_bad;
    logic               w_dec_bad;
    logic               w_slot;
    logic [NODE_W-1:0]  w_child;
    logic [CNT_W-1:0]   w_free;
    logic               w_room;
    logic               w_leaf;
    logic [NODE_W-1:0]  w_fresh;
    t_node              w_linked;
    t_node              w_named;
    logic [NODE_W-1:0]  w_raddr;
    logic               w_we;
    logic [NODE_W-1:0]  w_waddr;
    t_node              w_wdata;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_act  = t_action'(i_s_axis_tuser[1:0]);
    assign w_in_sym  = i_s_axis_tdata[7:0];
    assign w_in_bits = i_s_axis_tdata[39:8];
    assign w_in_len  = i_s_axis_tdata[45:40];
    assign w_ins_bad = (w_in_len == '0) || (w_in_len > LEN_W'(MAX_CODE_LEN));
    assign w_dec_bad = w_in_len > LEN_W'(BITS_PER_ITEM);

    assign w_slot  = !r_out_valid || i_m_axis_tready;
    assign w_child = r_bits[0] ? r_cur.rchild : r_cur.lchild;
    assign w_free  = CNT_W'(MAX_NODES) - r_used;
    assign w_room  = CMP_W'(r_left) <= CMP_W'(w_free);
    assign w_leaf  = (r_rdata.lchild == '0) && (r_rdata.rchild == '0);
    assign w_fresh = r_used[NODE_W-1:0];

    always_comb begin
        w_linked = r_cur;
        if (r_bits[0]) begin
            w_linked.rchild = w_fresh;
        end else begin
            w_linked.lchild = w_fresh;
        end
        w_named     = r_cur;
        w_named.sym = r_sym;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (w_in_act)
                        ACT_INSERT: n_state = w_ins_bad ? S_FINISH : S_STEP;
                        ACT_DECODE: begin
                            if (w_dec_bad) begin
                                n_state = S_FINISH;
                            end else if (r_walk == '0) begin
                                n_state = S_STEP;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_LOAD: n_state = S_STEP;
            S_STEP: begin
                if (r_left == '0) begin
                    n_state = r_insert ? S_SETSYM : S_FINISH;
                end else if (w_child == '0) begin
                    n_state = (r_insert && w_room) ? S_ALLOC : S_FINISH;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH:  n_state = (!r_insert && w_leaf) ? S_EMIT : S_STEP;
            S_EMIT:   n_state = w_slot ? S_STEP : S_EMIT;
            S_ALLOC:  n_state = (r_left == '0) ? S_SETSYM : S_ALLOC;
            S_SETSYM: n_state = S_FINISH;
            S_FINISH: n_state = w_slot ? S_IDLE : S_FINISH;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_root       = r_root;
        n_cur        = r_cur;
        n_node       = r_node;
        n_walk       = r_walk;
        n_used       = r_used;
        n_bits       = r_bits;
        n_left       = r_left;
        n_sym        = r_sym;
        n_insert     = r_insert;
        n_status     = r_status;
        n_emit_sym   = r_emit_sym;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_sym    = r_out_sym;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_bits   = w_in_bits;
                    n_left   = w_in_len;
                    n_sym    = w_in_sym;
                    n_insert = (w_in_act == ACT_INSERT);
                    n_status = ST_OK;
                    n_cur    = r_root;
                    n_node   = '0;
                    case (w_in_act)
                        ACT_CLEAR: begin
                            n_root = '0;
                            n_used = CNT_W'(1);
                            n_walk = '0;
                        end
                        ACT_INSERT: begin
                            if (w_ins_bad) begin
                                n_status = ST_BAD_LEN;
                            end
                        end
                        ACT_DECODE: begin
                            if (w_dec_bad) begin
                                n_status = ST_BAD_LEN;
                            end
                            n_node = r_walk;
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_LOAD: n_cur = r_rdata;
            S_STEP: begin
                if (r_left == '0) begin
                    if (!r_insert) begin
                        n_walk = r_node;
                    end
                end else if (w_child == '0) begin
                    if (!r_insert) begin
                        n_status = ST_MISSING;
                        n_walk   = '0;
                    end else if (!w_room) begin
                        n_status = ST_FULL;
                    end
                end else begin
                    n_node = w_child;
                    n_bits = r_bits >> 1;
                    n_left = r_left - LEN_W'(1);
                end
            end
            S_FETCH: begin
                n_cur      = r_rdata;
                n_emit_sym = r_rdata.sym;
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_SYMBOL;
                    n_out_sym    = r_emit_sym;
                    n_out_status = ST_OK;
                    n_out_last   = 1'b0;
                    n_cur        = r_root;
                    n_node       = '0;
                end
            end
            S_ALLOC: begin
                if (r_left != '0) begin
                    if (r_node == '0) begin
                        n_root = w_linked;
                    end
                    n_cur  = '0;
                    n_node = w_fresh;
                    n_used = r_used + CNT_W'(1);
                    n_bits = r_bits >> 1;
                    n_left = r_left - LEN_W'(1);
                end
            end
            S_SETSYM: begin
                if (r_node == '0) begin
                    n_root = w_named;
                end
            end
            S_FINISH: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_STATUS;
                    n_out_sym    = '0;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                end
            end
            default: n_cur = r_cur;
        endcase
    end

    // node memory controls
    always_comb begin
        w_raddr = (r_state == S_IDLE) ? r_walk : w_child;
        w_we    = 1'b0;
        w_waddr = r_node;
        w_wdata = w_named;
        case (r_state)
            S_ALLOC: begin
                w_we    = (r_left != '0) && (r_node != '0);
                w_wdata = w_linked;
            end
            S_SETSYM: w_we = (r_node != '0);
            default:  w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root      <= '0;
            r_used      <= CNT_W'(1);
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root      <= n_root;
            r_used      <= n_used;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_node       <= n_node;
        r_bits       <= n_bits;
        r_left       <= n_left;
        r_sym        <= n_sym;
        r_insert     <= n_insert;
        r_status     <= n_status;
        r_emit_sym   <= n_emit_sym;
        r_out_kind   <= n_out_kind;
        r_out_sym    <= n_out_sym;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - SYM_W - 2){1'b0}}, r_out_status, r_out_sym};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- design/hctd_checker.sv -----
module hctd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [hctd_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input logic [hctd_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [hctd_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [hctd_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    input logic                               o_m_axis_tlast
);
    import hctd_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an item is in progress");

    a_last_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser[0] == KIND_STATUS)))
        else $error("tlast does not match a status item");

    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser[0] == KIND_STATUS) ?
            (o_m_axis_tdata[7:0] == 8'd0) : (o_m_axis_tdata[9:8] == ST_OK)))
        else $error("unused output field not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output item changed");

endmodule

bind huffman_code_table_decoder hctd_checker u_hctd_checker (.*);
